// ===== src/smpq_pkg.sv =====
// shared constants, codes and types of the sorted max-priority queue
package smpq_pkg;

    // default number of cells in the row
    localparam int DEPTH_DEF = 64;

    // fixed field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // per-cell control from the row controller
    typedef struct packed {
        logic insert;    // insert request that the store can take
        logic remove;    // remove request on a non-empty store
        logic occupied;  // cell holds a valid entry
        logic at_end;    // cell is the first free position
    } smpq_cell_ctrl_t;

endpackage

// ===== src/smpq_cell.sv =====
// one cell of the sorted store: holds an entry, compares and shifts
module smpq_cell
    import smpq_pkg::*;
(
    input  logic                       clk,
    input  smpq_cell_ctrl_t            ctrl,
    input  logic signed [VALUE_W-1:0]  new_value,
    input  logic signed [VALUE_W-1:0]  left_value,
    input  logic                       left_take,
    input  logic signed [VALUE_W-1:0]  right_value,
    output logic signed [VALUE_W-1:0]  entry,
    output logic                       take
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    // new value goes at or ahead of this entry when it is not smaller
    assign take  = ctrl.occupied && (new_value >= entry_reg);
    assign entry = entry_reg;

    // shift right on insert, shift left on remove
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (left_take)
                entry_next = left_value;
            else if (take || ctrl.at_end)
                entry_next = new_value;
        end
        else if (ctrl.remove)
        begin
            entry_next = right_value;
        end
    end

    // entry storage, no reset: read only below the count
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/sorted_max_priority_queue.sv =====
// top level of the sorted max-priority queue: cell row, count and result register
//
// usage
//   a request is taken at a rising edge where start is high and busy is low;
//   mode selects insert (value is placed in order) or remove (head is returned)
//   busy stays low: the row of cells takes one request every clock cycle
//   the result appears on removed_value, status and occupancy in the cycle after
//   the request, for exactly one cycle, marked by done
//   throughput is one request per cycle, set by the row of DEPTH cells, which
//   all compare against the new value and shift toward their neighbor in the
//   same cycle
//   an insert into a full store returns the full status and changes nothing;
//   a remove on an empty store returns the empty status and a zero value
//   equal values leave newest first
//   reset clears the entry count and the done strobe; the cell contents are
//   not cleared, since only cells below the count are ever read
//   the receiver cannot stall: each result must be taken in its done cycle
module sorted_max_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       mode,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       done,
    output logic signed [VALUE_W-1:0]  removed_value,
    output logic [STATUS_W-1:0]        status,
    output logic [OCC_W-1:0]           occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       done_reg;
    logic signed [VALUE_W-1:0]  removed_value_reg;
    logic signed [VALUE_W-1:0]  removed_value_next;
    logic [STATUS_W-1:0]        status_reg;
    logic [STATUS_W-1:0]        status_next;
    logic [OCC_W-1:0]           occupancy_reg;

    logic                       accept;
    logic                       full;
    logic                       empty;
    logic                       do_insert;
    logic                       do_remove;

    logic signed [VALUE_W-1:0]  entries [DEPTH];
    logic                       takes   [DEPTH];

    // every cell compares and shifts in parallel, so requests never wait
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    assign do_insert = accept && (mode == MODE_INSERT) && !full;
    assign do_remove = accept && (mode == MODE_REMOVE) && !empty;

    // row of cells, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        smpq_cell_ctrl_t            ctrl;
        logic signed [VALUE_W-1:0]  left_value;
        logic                       left_take;
        logic signed [VALUE_W-1:0]  right_value;

        assign ctrl.insert   = do_insert;
        assign ctrl.remove   = do_remove;
        assign ctrl.occupied = (CNT_W'(i) < count_reg);
        assign ctrl.at_end   = (CNT_W'(i) == count_reg);

        if (i == 0)
        begin : g_head
            assign left_value = value;
            assign left_take  = 1'b0;
        end
        else
        begin : g_body
            assign left_value = entries[i-1];
            assign left_take  = takes[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_value = entries[i];
        end
        else
        begin : g_inner
            assign right_value = entries[i+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (value),
            .left_value  (left_value),
            .left_take   (left_take),
            .right_value (right_value),
            .entry       (entries[i]),
            .take        (takes[i])
        );
    end

    // count and result of the current request
    always_comb
    begin
        count_next         = count_reg;
        removed_value_next = '0;
        status_next        = STATUS_DONE;
        unique case (mode)
            MODE_INSERT:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            MODE_REMOVE:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    removed_value_next = entries[0];
                    count_next         = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_value_reg <= removed_value_next;
            status_reg        <= status_next;
            occupancy_reg     <= OCC_W'(count_next);
        end
    end

    assign done          = done_reg;
    assign removed_value = removed_value_reg;
    assign status        = status_reg;
    assign occupancy     = occupancy_reg;

    // every request gives a result strobe in the next cycle
    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("request without result strobe");

    // no strobe without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done_reg)
        else $error("result strobe without request");

    // the count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // a refused insert leaves the store full
    a_full_held: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STATUS_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full status with store not full");

    // a remove on empty returns zero and leaves the store empty
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STATUS_EMPTY))
            |-> ((removed_value_reg == '0) && (count_reg == '0)))
        else $error("empty status with data or entries");

endmodule
